/* hdl/delimited_frame_receiver_assert.svh */
// Assertion macros for the delimited frame receiver.
// Used only by the top level; the macros expect clk and rst_n in scope.
`ifndef DELIMITED_FRAME_RECEIVER_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define DFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DFR_ASSERT_SAME(label, ante, cons, msg)
`define DFR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hdl/dfr_pkg.sv */
// Shared types and constants for the delimited frame receiver.
// No dependencies.
package dfr_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_END_BYTE   = 2'd1;
    localparam logic [1:0] CFG_VERSION    = 2'd2;

    localparam logic [7:0] START_BYTE_RST = 8'hAA;
    localparam logic [7:0] END_BYTE_RST   = 8'h55;
    localparam logic [7:0] VERSION_RST    = 8'h01;

    // frame layout: 3 start + version + 2 length, then 2 sum + 3 end
    localparam int unsigned HDR_LEN  = 6;
    localparam int unsigned TAIL_LEN = 5;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SUM_ERR  = 3'd1,
        ST_LEN_ERR  = 3'd2,
        ST_VER_ERR  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic {
        RX_HUNT  = 1'b0,
        RX_FRAME = 1'b1
    } rx_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload;
        status_t     status;
        logic [15:0] length;
    } result_t;

endpackage

/* hdl/delimited_frame_receiver.sv */
// Delimited frame receiver: byte-stream deframer with a subtractive 16-bit sum check.
// Depends on dfr_pkg and delimited_frame_receiver_assert.svh.
//
// Usage:
//   s_* takes one received byte per word (s_tdata[7:0]). Bytes are dropped until
//   three start bytes arrive in a row; then version, 16-bit LE length, payload,
//   16-bit LE sum and three end bytes follow.
//   m_* gives one word per payload byte (m_tuser = 0) and one status word at
//   frame end or on overflow (m_tuser = 1). Header, sum and delimiter bytes
//   give no word.
//   cfg_we/cfg_addr/cfg_wdata write start byte, end byte and expected version;
//   write only while no word is in flight.
// Timing: one byte is accepted every cycle while s_tready is high; its result word
//   is registered in the output register, or in the skid entry while that is held.
//   The skid entry lets the input keep flowing after m_tready drops until a second
//   word is waiting; s_tready falls only once the skid entry is occupied.
// Reset: clears the frame state, empties the output and restores the register
//   defaults (start 0xAA, end 0x55, version 1). No clearing pass is needed.
module delimited_frame_receiver #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] payload_byte, [10:8] frame_status,
                                    // [26:11] declared_length, [31:27] zero
    output logic        m_tuser,    // [0] item_kind
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + 12);
    localparam int CW    = ((POS_W > 17) ? POS_W : 17) + 1;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PAYLOAD + 11);
    localparam logic [CW-1:0]    C_HDR     = CW'(dfr_pkg::HDR_LEN);
    localparam logic [CW-1:0]    C_FULL    = CW'(dfr_pkg::HDR_LEN + dfr_pkg::TAIL_LEN);

    // configuration registers
    logic [7:0] start_byte_reg, end_byte_reg, version_exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= dfr_pkg::START_BYTE_RST;
            end_byte_reg    <= dfr_pkg::END_BYTE_RST;
            version_exp_reg <= dfr_pkg::VERSION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dfr_pkg::CFG_START_BYTE: start_byte_reg  <= cfg_wdata;
                dfr_pkg::CFG_END_BYTE:   end_byte_reg    <= cfg_wdata;
                dfr_pkg::CFG_VERSION:    version_exp_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // frame state
    dfr_pkg::rx_state_t state_reg, state_next;
    logic [1:0]       start_run_reg, start_run_next;
    logic [1:0]       end_run_reg, end_run_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       ver_reg, ver_next;
    logic [15:0]      rsum_reg, rsum_next;
    logic [15:0]      rcv_reg, rcv_next;

    logic             accept;
    logic             start_done;
    logic             frame_close;
    logic             res_valid;
    dfr_pkg::result_t res;

    logic [7:0]    b;
    logic [CW-1:0] p_ext, total, sum_end, sum_end_j;
    logic [15:0]   sub_val;

    assign b      = s_tdata;
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dfr_pkg::RX_HUNT:  if (accept && start_done) state_next = dfr_pkg::RX_FRAME;
            dfr_pkg::RX_FRAME: if (accept && frame_close) state_next = dfr_pkg::RX_HUNT;
            default:           state_next = dfr_pkg::RX_HUNT;
        endcase
    end

    always_comb
    begin
        start_run_next = start_run_reg;
        end_run_next   = end_run_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        ver_next       = ver_reg;
        rsum_next      = rsum_reg;
        rcv_next       = rcv_reg;
        start_done     = 1'b0;
        frame_close    = 1'b0;
        res_valid      = 1'b0;
        res.kind       = dfr_pkg::KIND_PAYLOAD;
        res.payload    = 8'h00;
        res.status     = dfr_pkg::ST_OK;
        res.length     = len_reg;

        p_ext     = CW'(pos_reg);
        total     = p_ext + CW'(1);
        sum_end   = C_HDR + CW'(len_reg);
        sum_end_j = sum_end;
        sub_val   = {8'h00, b};

        if (accept)
        begin
            if (state_reg == dfr_pkg::RX_HUNT)
            begin
                if (b == start_byte_reg)
                begin
                    if (start_run_reg == 2'd2)
                    begin
                        start_done     = 1'b1;
                        start_run_next = 2'd0;
                        end_run_next   = 2'd0;
                        pos_next       = POS_W'(3);
                        len_next       = 16'h0000;
                        ver_next       = 8'h00;
                        rcv_next       = 16'h0000;
                        // delimiter bytes land as low, high, low
                        rsum_next      = 16'h0000 - {b, b} - {8'h00, b};
                    end
                    else
                    begin
                        start_run_next = start_run_reg + 2'd1;
                    end
                end
                else
                begin
                    start_run_next = 2'd0;
                end
            end
            else if (pos_reg >= POS_LIMIT)
            begin
                frame_close    = 1'b1;
                start_run_next = 2'd0;
                end_run_next   = 2'd0;
                res_valid      = 1'b1;
                res.kind       = dfr_pkg::KIND_STATUS;
                res.status     = dfr_pkg::ST_OVERFLOW;
            end
            else
            begin
                if (p_ext < C_HDR || p_ext < sum_end)
                begin
                    if (pos_reg[0])
                        sub_val = {b, 8'h00};
                    else if (p_ext >= C_HDR && total == sum_end)
                        sub_val = {b, 8'h00};   // odd last byte counts high
                    rsum_next = rsum_reg - sub_val;
                end
                else if (p_ext == sum_end)
                    rcv_next = {8'h00, b};
                else if (p_ext == sum_end + CW'(1))
                    rcv_next = {b, rcv_reg[7:0]};

                if (pos_reg == POS_W'(3))
                    ver_next = b;
                else if (pos_reg == POS_W'(4))
                    len_next = {8'h00, b};
                else if (pos_reg == POS_W'(5))
                    len_next = {b, len_reg[7:0]};

                if (b == end_byte_reg)
                    end_run_next = (end_run_reg == 2'd3) ? end_run_reg : end_run_reg + 2'd1;
                else
                    end_run_next = 2'd0;
                pos_next = pos_reg + POS_W'(1);

                sum_end_j  = C_HDR + CW'(len_next);
                res.length = len_next;

                if (end_run_next == 2'd3)
                begin
                    frame_close    = 1'b1;
                    start_run_next = 2'd0;
                    end_run_next   = 2'd0;
                    res_valid      = 1'b1;
                    res.kind       = dfr_pkg::KIND_STATUS;
                    if (total < C_HDR + CW'(2))
                        res.status = dfr_pkg::ST_LEN_ERR;
                    else if (total < sum_end_j + CW'(2))
                        res.status = dfr_pkg::ST_SUM_ERR;
                    else if (rsum_next != rcv_next)
                        res.status = dfr_pkg::ST_SUM_ERR;
                    else if (total != CW'(len_next) + C_FULL)
                        res.status = dfr_pkg::ST_LEN_ERR;
                    else if (ver_next != version_exp_reg)
                        res.status = dfr_pkg::ST_VER_ERR;
                    else
                        res.status = dfr_pkg::ST_OK;
                end
                else if (p_ext >= C_HDR && p_ext < sum_end)
                begin
                    res_valid   = 1'b1;
                    res.payload = b;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dfr_pkg::RX_HUNT;
            start_run_reg <= 2'd0;
            end_run_reg   <= 2'd0;
            pos_reg       <= '0;
            len_reg       <= 16'h0000;
            ver_reg       <= 8'h00;
            rsum_reg      <= 16'h0000;
            rcv_reg       <= 16'h0000;
        end
        else
        begin
            state_reg     <= state_next;
            start_run_reg <= start_run_next;
            end_run_reg   <= end_run_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            ver_reg       <= ver_next;
            rsum_reg      <= rsum_next;
            rcv_reg       <= rcv_next;
        end
    end

    // output register plus one skid entry
    logic             out_valid_reg, skid_valid_reg;
    dfr_pkg::result_t out_reg, skid_reg;
    logic             out_fire;

    assign out_fire = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'b00000, out_reg.length, out_reg.status, out_reg.payload};

`include "delimited_frame_receiver_assert.svh"

    `DFR_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg,
                     "skid word without output word")
    `DFR_ASSERT_SAME(a_payload_status_ok, m_tvalid && !m_tuser, m_tdata[10:8] == 3'd0,
                     "payload word with nonzero status")
    `DFR_ASSERT_NEXT(a_status_ends_frame, res_valid && res.kind == dfr_pkg::KIND_STATUS,
                     state_reg == dfr_pkg::RX_HUNT, "status word did not return to hunting")
    `DFR_ASSERT_SAME(a_pos_bounded, state_reg == dfr_pkg::RX_FRAME, pos_reg <= POS_LIMIT,
                     "byte position past overflow limit")

endmodule
